FILE: design/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared codes, widths and item layouts of the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // Action codes carried in the input item
  localparam logic [2:0] ACT_STORE = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_FREE  = 3'd2;
  localparam logic [2:0] ACT_QUERY = 3'd3;
  localparam logic [2:0] ACT_INFO  = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  // Result status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_BAD    = 2'd1;
  localparam logic [1:0] STS_NOCAP  = 2'd2;
  localparam logic [1:0] STS_NOSLOT = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'd1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 144;

  // Input item, fields listed from the highest bits down
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] buffer_size;
    logic [31:0] size;
    logic [5:0]  slot;
    logic [2:0]  action;
  } in_item_t;

  // Result item, fields listed from the highest bits down
  typedef struct packed {
    logic [31:0] load_count;
    logic [31:0] store_count;
    logic [6:0]  slots_in_use;
    logic [31:0] bytes_in_use;
    logic        slot_used;
    logic [31:0] slot_size;
    logic [5:0]  slot_id;
    logic [1:0]  status;
  } out_item_t;

endpackage

FILE: design/ssa_ram.sv
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ssa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/swap_slot_allocator.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator
// First-fit slot table with a byte budget: store, load, free, query, info
// and clear actions, slot sizes held in a RAM, used marks in flops.
// ----------------------------------------------------------------------------
//  Channel     Direction  Handshake                 Carries
//  s_axis      in         tvalid/tready             one action request
//  m_axis      out        tvalid/tready             one result per request
//  cfg         in         we (no back-pressure)     capacity, slot limit
//
//  The accept cycle issues the size RAM read; the execute state then runs
//  the free-slot search, checks and write-back. A new request is accepted
//  only once the last one has left the execute state. The result sits in
//  an output register; a stalled output holds the request in its execute
//  state, and a new request is taken while a result still waits. Reset
//  clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module swap_slot_allocator #(
  parameter int unsigned NumSlots = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // action[2:0], slot[8:3], size[40:9], buffer_size[72:41], zero pad
  input  logic [ssa_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // status[1:0], slot_id[7:2], slot_size[39:8], slot_used[40],
  // bytes_in_use[72:41], slots_in_use[79:73], store_count[111:80],
  // load_count[143:112]
  output logic [ssa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_we_i,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  import ssa_pkg::*;

  localparam int unsigned IdxW = $clog2(NumSlots);
  localparam int unsigned CntW = $clog2(NumSlots + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e              state_q, state_d;
  in_item_t            item_q, item_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [NumSlots-1:0] used_q, used_d;
  logic [31:0]         bytes_q, bytes_d;
  logic [CntW-1:0]     slots_q, slots_d;
  logic [31:0]         stores_q, stores_d;
  logic [31:0]         loads_q, loads_d;
  logic [31:0]         cap_q;
  logic [6:0]          limit_reg_q;

  in_item_t            s_item;
  logic                s_accept;
  logic                exec_go;
  logic [CntW-1:0]     eff_limit;
  logic [NumSlots-1:0] lim_mask;
  logic [NumSlots-1:0] avail;
  logic [NumSlots-1:0] lowest;
  logic                found;
  logic [IdxW-1:0]     found_idx;
  logic [IdxW-1:0]     slot_idx;
  logic                in_range;
  logic                slot_marked;
  logic [32:0]         total;
  logic [31:0]         rd_size;
  logic                ram_we;

  assign s_item   = in_item_t'(s_axis_tdata_i);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign exec_go  = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);

  // zero or oversized limit register means the whole table
  assign eff_limit = (limit_reg_q == 7'd0 || 32'(limit_reg_q) > NumSlots)
                   ? CntW'(NumSlots) : CntW'(limit_reg_q);

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      lim_mask[i] = 32'(i) < 32'(eff_limit);
    end
  end

  // lowest free slot below the limit: isolate the lowest set bit
  assign avail  = ~used_q & lim_mask;
  assign lowest = avail & (~avail + NumSlots'(1));
  assign found  = |avail;

  always_comb begin
    found_idx = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (lowest[i]) begin
        found_idx = found_idx | IdxW'(i);
      end
    end
  end

  assign slot_idx    = IdxW'(item_q.slot);
  assign in_range    = 32'(item_q.slot) < 32'(eff_limit);
  assign slot_marked = in_range && used_q[slot_idx];
  assign total       = {1'b0, bytes_q} + {1'b0, item_q.size};

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    used_d      = used_q;
    bytes_d     = bytes_q;
    slots_d     = slots_q;
    stores_d    = stores_q;
    loads_d     = loads_q;
    ram_we      = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          item_d  = s_item;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = STS_OK;
          case (item_q.action)
            ACT_STORE: begin
              if (item_q.size == 32'd0) begin
                out_d.status = STS_BAD;
              end else if (total > {1'b0, cap_q}) begin
                out_d.status = STS_NOCAP;
              end else if (!found) begin
                out_d.status = STS_NOSLOT;
              end else begin
                ram_we            = 1'b1;
                used_d[found_idx] = 1'b1;
                bytes_d           = total[31:0];
                slots_d           = slots_q + CntW'(1);
                stores_d          = stores_q + 32'd1;
                out_d.slot_id     = 6'(found_idx);
              end
            end
            ACT_LOAD: begin
              if (!slot_marked || item_q.buffer_size < rd_size) begin
                out_d.status = STS_BAD;
              end else begin
                loads_d         = loads_q + 32'd1;
                out_d.slot_size = rd_size;
              end
            end
            ACT_FREE: begin
              if (!slot_marked) begin
                out_d.status = STS_BAD;
              end else begin
                bytes_d = (bytes_q >= rd_size) ? bytes_q - rd_size : 32'd0;
                used_d[slot_idx] = 1'b0;
                if (slots_q != '0) begin
                  slots_d = slots_q - CntW'(1);
                end
              end
            end
            ACT_QUERY: begin
              out_d.slot_used = slot_marked;
            end
            ACT_INFO: begin
              out_d.bytes_in_use = bytes_q;
              out_d.slots_in_use = 7'(slots_q);
              out_d.store_count  = stores_q;
              out_d.load_count   = loads_q;
            end
            ACT_CLEAR: begin
              used_d   = '0;
              bytes_d  = '0;
              slots_d  = '0;
              stores_d = '0;
              loads_d  = '0;
            end
            default: begin
              out_d.status = STS_BAD;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      bytes_q     <= '0;
      slots_q     <= '0;
      stores_q    <= '0;
      loads_q     <= '0;
      cap_q       <= '0;
      limit_reg_q <= 7'd64;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      bytes_q     <= bytes_d;
      slots_q     <= slots_d;
      stores_q    <= stores_d;
      loads_q     <= loads_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CAPACITY:   cap_q       <= cfg_wdata_i;
          CFG_SLOT_LIMIT: limit_reg_q <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // slot sizes are only used for slots with a used mark, so no reset needed
  ssa_ram #(
    .Width (32),
    .Depth (NumSlots)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (found_idx),
    .wdata_i (item_q.size),
    .re_i    (s_accept),
    .raddr_i (IdxW'(s_item.slot)),
    .rdata_o (rd_size)
  );

  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);
  assign m_axis_tvalid_o = out_valid_q;

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == ST_EXEC)
    else $error("accepted request did not enter execute");

  a_result_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without an execute cycle");

  a_slot_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slots_q) == 32'($countones(used_q)))
    else $error("slot count disagrees with used marks");

  a_store_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !used_q[found_idx] && lim_mask[found_idx])
    else $error("store wrote a slot already in use");

endmodule

FILE: tb/swap_slot_allocator_checker.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator_checker
// Watches the request, result and register channels of the slot allocator.
// It keeps its own slot table and totals, works out the result of every
// accepted request and compares each returned result field by field, in
// order.
// ----------------------------------------------------------------------------
module swap_slot_allocator_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ssa_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  input  logic                              s_axis_tready_i,
  input  logic [ssa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_i,
  input  logic                              m_axis_tvalid_i,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output int unsigned                       errors_o,
  output int unsigned                       outstanding_o,
  output int unsigned                       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssa_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;

  logic        used_mark [TABLE_DEPTH];
  logic [31:0] slot_len  [TABLE_DEPTH];
  logic [31:0] bytes_held;
  logic [6:0]  slots_held;
  logic [31:0] stores_done;
  logic [31:0] loads_done;
  logic [31:0] capacity;
  logic [6:0]  slot_limit;

  out_item_t   awaited_results [$];
  out_item_t   got;
  out_item_t   want;
  int unsigned mismatch_count = 0;
  int unsigned compared_count = 0;
  int unsigned queued_count   = 0;

  assign errors_o      = mismatch_count;
  assign outstanding_o = queued_count;
  assign checked_o     = compared_count;

  function automatic void clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      used_mark[i] = 1'b0;
      slot_len[i]  = '0;
    end
    bytes_held  = '0;
    slots_held  = '0;
    stores_done = '0;
    loads_done  = '0;
  endfunction

  // Apply one request to the table and return the result it must produce
  function automatic out_item_t table_response(in_item_t req);
    out_item_t   res;
    int unsigned lim;
    int unsigned found;
    logic        in_range;
    logic [32:0] total;
    res      = '0;
    lim      = (slot_limit == 0 || slot_limit > TABLE_DEPTH) ? TABLE_DEPTH : slot_limit;
    in_range = req.slot < lim;
    case (req.action)
      ACT_STORE: begin
        total = {1'b0, bytes_held} + {1'b0, req.size};
        found = lim;
        for (int i = int'(lim) - 1; i >= 0; i--) begin
          if (!used_mark[i]) found = i;
        end
        if (req.size == 0) begin
          res.status = STS_BAD;
        end else if (total > {1'b0, capacity}) begin
          res.status = STS_NOCAP;
        end else if (found >= lim) begin
          res.status = STS_NOSLOT;
        end else begin
          used_mark[found] = 1'b1;
          slot_len[found]  = req.size;
          bytes_held       = total[31:0];
          slots_held++;
          stores_done++;
          res.status  = STS_OK;
          res.slot_id = 6'(found);
        end
      end
      ACT_LOAD: begin
        if (!in_range || !used_mark[req.slot] || req.buffer_size < slot_len[req.slot]) begin
          res.status = STS_BAD;
        end else begin
          loads_done++;
          res.status    = STS_OK;
          res.slot_size = slot_len[req.slot];
        end
      end
      ACT_FREE: begin
        if (!in_range || !used_mark[req.slot]) begin
          res.status = STS_BAD;
        end else begin
          // saturate at zero
          bytes_held = (bytes_held >= slot_len[req.slot]) ?
                       bytes_held - slot_len[req.slot] : '0;
          used_mark[req.slot] = 1'b0;
          slot_len[req.slot]  = '0;
          if (slots_held != 0) slots_held--;
          res.status = STS_OK;
        end
      end
      ACT_QUERY: begin
        res.status    = STS_OK;
        res.slot_used = in_range && used_mark[req.slot];
      end
      ACT_INFO: begin
        res.status       = STS_OK;
        res.bytes_in_use = bytes_held;
        res.slots_in_use = slots_held;
        res.store_count  = stores_done;
        res.load_count   = loads_done;
      end
      ACT_CLEAR: begin
        clear_table();
        res.status = STS_OK;
      end
      default: begin
        res.status = STS_BAD;
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity   = '0;
      slot_limit = 7'd64;
      clear_table();
      awaited_results.delete();
      queued_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY:   capacity   = cfg_wdata_i;
          CFG_SLOT_LIMIT: slot_limit = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        awaited_results.push_back(table_response(in_item_t'(s_axis_tdata_i)));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = out_item_t'(m_axis_tdata_i);
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transfer with nothing expected, got 0x%0h", $time, got);
        end else begin
          want = awaited_results.pop_front();
          check_field("status",       32'(want.status),       32'(got.status));
          check_field("slot_id",      32'(want.slot_id),      32'(got.slot_id));
          check_field("slot_size",    want.slot_size,         got.slot_size);
          check_field("slot_used",    32'(want.slot_used),    32'(got.slot_used));
          check_field("bytes_in_use", want.bytes_in_use,      got.bytes_in_use);
          check_field("slots_in_use", 32'(want.slots_in_use), 32'(got.slots_in_use));
          check_field("store_count",  want.store_count,       got.store_count);
          check_field("load_count",   want.load_count,        got.load_count);
          compared_count++;
        end
      end
      queued_count = awaited_results.size();
    end
  end

endmodule

FILE: tb/swap_slot_allocator_test.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator_test
// Drives the slot allocator with a directed set of corner requests, then
// phases of random requests under different budgets and slot limits, with
// random idle cycles on both streams and one long result stall. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module swap_slot_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssa_pkg::*;

  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam logic [2:0]  ACT_RSVD_A  = 3'd6;
  localparam logic [2:0]  ACT_RSVD_B  = 3'd7;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx   = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned sent     = 0;
  int unsigned settings = 0;
  int unsigned cur_limit = 64;
  bit          steady   = 1'b0;
  bit          hold_req = 1'b0;

  swap_slot_allocator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  swap_slot_allocator_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .errors_o        (errors),
    .outstanding_o   (outstanding),
    .checked_o       (checked)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("Timed out after %0d cycles with %0d results outstanding", RUN_LIMIT, outstanding);
    $display("swap_slot_allocator_test: errors");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  function automatic in_item_t make_request(logic [2:0] action, logic [5:0] slot,
                                            logic [31:0] size, logic [31:0] buf_len);
    in_item_t req;
    req             = '0;
    req.action      = action;
    req.slot        = slot;
    req.size        = size;
    req.buffer_size = buf_len;
    return req;
  endfunction

  // Keep tvalid high into the next request when there is no gap
  task automatic send_request(in_item_t req);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= req;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  // Drop tvalid and wait until every expected result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [31:0] cap, logic [6:0] lim);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_idx   <= CFG_SLOT_LIMIT;
    cfg_wdata <= {25'd0, lim};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_limit = (lim == 0 || lim > 64) ? 64 : lim;
    settings++;
  endtask

  // Mostly stores and frees on the low slots, with some noise
  function automatic in_item_t random_request();
    int unsigned pick;
    int unsigned hi;
    logic [2:0]  action;
    logic [5:0]  slot;
    logic [31:0] size;
    logic [31:0] buf_len;
    pick = $urandom_range(0, 99);
    if (pick < 35)      action = ACT_STORE;
    else if (pick < 55) action = ACT_LOAD;
    else if (pick < 80) action = ACT_FREE;
    else if (pick < 88) action = ACT_QUERY;
    else if (pick < 96) action = ACT_INFO;
    else if (pick < 98) action = ACT_CLEAR;
    else                action = $urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B;
    hi = (cur_limit < 12) ? cur_limit : 12;
    slot = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, hi - 1)) : 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 4)       size = '0;
    else if (pick < 10) size = $urandom();
    else                size = $urandom_range(1, 300);
    pick = $urandom_range(0, 3);
    if (pick < 2)       buf_len = 32'hFFFF_FFFF;
    else if (pick == 2) buf_len = $urandom();
    else                buf_len = $urandom_range(0, 300);
    return make_request(action, slot, size, buf_len);
  endfunction

  initial begin
    logic [6:0]  lim_choices [PHASES];
    logic [31:0] cap;
    lim_choices = '{7'd127, 7'd0, 7'd1, 7'd64, 7'd2, 7'd65, 7'd5, 7'd33, 7'd64};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full budget: zero size, wrap of the byte sum, load buffer bounds
    program_regs(32'hFFFF_FFFF, 7'd0);
    send_request(make_request(ACT_STORE, 6'd0, 32'd0, 32'd0));
    send_request(make_request(ACT_STORE, 6'd0, 32'hFFFF_FFFF, 32'd0));
    send_request(make_request(ACT_STORE, 6'd0, 32'd1, 32'd0));
    send_request(make_request(ACT_INFO, 6'd0, 32'd0, 32'd0));
    send_request(make_request(ACT_LOAD, 6'd0, 32'd0, 32'hFFFF_FFFE));
    send_request(make_request(ACT_LOAD, 6'd0, 32'd0, 32'hFFFF_FFFF));
    send_request(make_request(ACT_QUERY, 6'd0, 32'd0, 32'd0));
    send_request(make_request(ACT_FREE, 6'd0, 32'd0, 32'd0));
    send_request(make_request(ACT_FREE, 6'd0, 32'd0, 32'd0));
    send_request(make_request(ACT_RSVD_A, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(ACT_RSVD_B, 6'd0, 32'd0, 32'd0));
    send_request(make_request(ACT_STORE, 6'd0, 32'd10, 32'd0));
    send_request(make_request(ACT_CLEAR, 6'd0, 32'd0, 32'd0));
    send_request(make_request(ACT_INFO, 6'd0, 32'd0, 32'd0));

    // One slot, small budget: no capacity, then full table
    program_regs(32'd100, 7'd1);
    send_request(make_request(ACT_STORE, 6'd0, 32'd60, 32'd0));
    send_request(make_request(ACT_STORE, 6'd0, 32'd50, 32'd0));
    send_request(make_request(ACT_STORE, 6'd0, 32'd40, 32'd0));
    send_request(make_request(ACT_QUERY, 6'd1, 32'd0, 32'd0));

    // Fill two more slots, then lower the limit below the higher one
    program_regs(32'hFFFF_FFFF, 7'd64);
    send_request(make_request(ACT_STORE, 6'd0, 32'd5, 32'd0));
    send_request(make_request(ACT_STORE, 6'd0, 32'd7, 32'd0));
    program_regs(32'hFFFF_FFFF, 7'd2);
    send_request(make_request(ACT_LOAD, 6'd2, 32'd0, 32'hFFFF_FFFF));
    send_request(make_request(ACT_FREE, 6'd2, 32'd0, 32'd0));
    send_request(make_request(ACT_QUERY, 6'd2, 32'd0, 32'd0));
    send_request(make_request(ACT_INFO, 6'd0, 32'd0, 32'd0));

    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       cap = $urandom_range(200, 4000);
        1:       cap = 32'hFFFF_FFFF;
        default: cap = $urandom();
      endcase
      if (p == 4) cap = '0;
      program_regs(cap, lim_choices[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) steady = ($urandom_range(0, 3) == 0);
        // back up the result side and keep offering requests
        if (p == 5 && n == 0) begin
          steady   = 1'b1;
          hold_req = 1'b1;
        end
        send_request(random_request());
      end
      steady = 1'b0;
    end

    settle();
    $display("Ran %0d requests over %0d register settings, %0d results compared",
             sent, settings, checked);
    $display("Covered all actions, budget and table limits, lowered limits and a long stall");
    if (errors == 0) begin
      $display("swap_slot_allocator_test: clean");
    end else begin
      $display("swap_slot_allocator_test: errors");
    end
    $finish;
  end

endmodule
